>>> rtl/scta_pkg.sv
`timescale 1ns / 1ps

package scta_pkg;

  // Ring depth default and queue depth between the front and the back.
  localparam int RING_DEPTH_DEFAULT = 256;
  localparam int QUEUE_DEPTH        = 2;

  // Operation codes on the input channel.
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Scancodes that move the modifier flags.
  localparam logic [7:0] SC_LSHIFT_PRESS   = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_PRESS   = 8'h36;
  localparam logic [7:0] SC_LSHIFT_RELEASE = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_RELEASE = 8'hB6;
  localparam logic [7:0] SC_CAPS_PRESS     = 8'h3A;
  localparam logic [7:0] SC_CTRL_PRESS     = 8'h1D;
  localparam logic [7:0] SC_CTRL_RELEASE   = 8'h9D;

  // Other codes stored raw.
  localparam logic [7:0] SC_ESC   = 8'h01;
  localparam logic [7:0] SC_F1    = 8'h3B;
  localparam logic [7:0] SC_UP    = 8'h48;
  localparam logic [7:0] SC_LEFT  = 8'h4B;
  localparam logic [7:0] SC_RIGHT = 8'h4D;
  localparam logic [7:0] SC_DOWN  = 8'h50;

  // Highest press code that produces a ring entry; table size.
  localparam logic [7:0] SC_MAX_PRESS  = 8'h70;
  localparam logic [7:0] SC_TABLE_KEYS = 8'd58;

  // Characters used on the read side.
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_LOWER_S = 8'h73;
  localparam logic [7:0] CH_UPPER_S = 8'h53;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // One queued command for the back end.
  typedef struct packed {
    logic       is_read;
    logic       ctrl;
    logic [7:0] value;
  } cmd_t;

  // Codes kept raw in the ring.
  function automatic logic is_special(input logic [7:0] c);
    logic r;
    r = (c == SC_ESC) || (c == SC_LSHIFT_PRESS) || (c == SC_RSHIFT_PRESS) ||
        (c == SC_CAPS_PRESS) || (c == SC_F1) || (c == SC_UP) ||
        (c == SC_LEFT) || (c == SC_RIGHT) || (c == SC_DOWN);
    return r;
  endfunction

  // Entry values dropped on read: special codes other than '6', ':' and ';'.
  function automatic logic is_skipped(input logic [7:0] v);
    logic r;
    r = (v == SC_ESC) || (v == SC_LSHIFT_PRESS) || (v == SC_UP) ||
        (v == SC_LEFT) || (v == SC_RIGHT) || (v == SC_DOWN);
    return r;
  endfunction

  // Key table: {shifted, plain}.
  function automatic logic [15:0] key_lookup(input logic [5:0] k);
    logic [15:0] r;
    unique case (k)
      6'd1:  r = 16'h1B1B;
      6'd2:  r = 16'h2131;
      6'd3:  r = 16'h4032;
      6'd4:  r = 16'h2333;
      6'd5:  r = 16'h2434;
      6'd6:  r = 16'h2535;
      6'd7:  r = 16'h5E36;
      6'd8:  r = 16'h2637;
      6'd9:  r = 16'h2A38;
      6'd10: r = 16'h2839;
      6'd11: r = 16'h2930;
      6'd12: r = 16'h5F2D;
      6'd13: r = 16'h2B3D;
      6'd14: r = 16'h0808;
      6'd15: r = 16'h0909;
      6'd16: r = 16'h5171;
      6'd17: r = 16'h5777;
      6'd18: r = 16'h4565;
      6'd19: r = 16'h5272;
      6'd20: r = 16'h5474;
      6'd21: r = 16'h5979;
      6'd22: r = 16'h5575;
      6'd23: r = 16'h4969;
      6'd24: r = 16'h4F6F;
      6'd25: r = 16'h5070;
      6'd26: r = 16'h7B5B;
      6'd27: r = 16'h7D5D;
      6'd28: r = 16'h0A0A;
      6'd30: r = 16'h4161;
      6'd31: r = 16'h5373;
      6'd32: r = 16'h4464;
      6'd33: r = 16'h4666;
      6'd34: r = 16'h4767;
      6'd35: r = 16'h4868;
      6'd36: r = 16'h4A6A;
      6'd37: r = 16'h4B6B;
      6'd38: r = 16'h4C6C;
      6'd39: r = 16'h3A3B;
      6'd40: r = 16'h2227;
      6'd41: r = 16'h7E60;
      6'd43: r = 16'h7C5C;
      6'd44: r = 16'h5A7A;
      6'd45: r = 16'h5878;
      6'd46: r = 16'h4363;
      6'd47: r = 16'h5676;
      6'd48: r = 16'h4262;
      6'd49: r = 16'h4E6E;
      6'd50: r = 16'h4D6D;
      6'd51: r = 16'h3C2C;
      6'd52: r = 16'h3E2E;
      6'd53: r = 16'h3F2F;
      6'd57: r = 16'h2020;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/scta_ram.sv
`timescale 1ns / 1ps

module scta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/scta_front.sv
`timescale 1ns / 1ps

module scta_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              in_operation,
  input  logic [7:0]        in_scan_code,
  output logic              push,
  output scta_pkg::cmd_t    push_cmd
);

  logic shift_r, shift_nxt;
  logic caps_r, caps_nxt;
  logic ctrl_r, ctrl_nxt;
  logic [15:0] key_pair;
  logic [7:0]  plain;
  logic        col;

  always_comb begin
    shift_nxt = shift_r;
    caps_nxt  = caps_r;
    ctrl_nxt  = ctrl_r;
    push      = 1'b0;
    push_cmd  = '0;
    key_pair  = scta_pkg::key_lookup(in_scan_code[5:0]);
    plain     = key_pair[7:0];
    col       = 1'b0;

    if (accept && (in_operation == scta_pkg::OP_READ)) begin
      // Reads carry the control flag as it stands now.
      push             = 1'b1;
      push_cmd.is_read = 1'b1;
      push_cmd.ctrl    = ctrl_r;
    end else if (accept) begin
      if ((in_scan_code == scta_pkg::SC_LSHIFT_PRESS) ||
          (in_scan_code == scta_pkg::SC_RSHIFT_PRESS)) begin
        shift_nxt = 1'b1;
      end
      if ((in_scan_code == scta_pkg::SC_LSHIFT_RELEASE) ||
          (in_scan_code == scta_pkg::SC_RSHIFT_RELEASE)) begin
        shift_nxt = 1'b0;
      end
      if (in_scan_code == scta_pkg::SC_CAPS_PRESS) begin
        caps_nxt = ~caps_r;
      end
      if (in_scan_code == scta_pkg::SC_CTRL_PRESS) begin
        ctrl_nxt = 1'b1;
      end
      if (in_scan_code == scta_pkg::SC_CTRL_RELEASE) begin
        ctrl_nxt = 1'b0;
      end

      if (in_scan_code <= scta_pkg::SC_MAX_PRESS) begin
        push = 1'b1;
        // Caps lock flips the column for letters only.
        col = shift_nxt ^ (caps_nxt && (plain >= scta_pkg::CH_LOWER_A) &&
                                       (plain <= scta_pkg::CH_LOWER_Z));
        priority if (scta_pkg::is_special(in_scan_code)) begin
          push_cmd.value = in_scan_code;
        end else if (in_scan_code < scta_pkg::SC_TABLE_KEYS) begin
          push_cmd.value = col ? key_pair[15:8] : plain;
        end else begin
          push_cmd.value = 8'h00;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      caps_r  <= 1'b0;
      ctrl_r  <= 1'b0;
    end else begin
      shift_r <= shift_nxt;
      caps_r  <= caps_nxt;
      ctrl_r  <= ctrl_nxt;
    end
  end

endmodule

>>> rtl/scta_queue.sv
`timescale 1ns / 1ps

module scta_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  scta_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output scta_pkg::cmd_t head
);

  localparam int QW = $clog2(scta_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(scta_pkg::QUEUE_DEPTH + 1);

  scta_pkg::cmd_t slot_r [0:scta_pkg::QUEUE_DEPTH-1];
  logic [QW-1:0] wr_r, wr_nxt;
  logic [QW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(scta_pkg::QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = slot_r[rd_r];

  always_comb begin
    wr_nxt    = push ? wr_r + 1'b1 : wr_r;
    rd_nxt    = pop ? rd_r + 1'b1 : rd_r;
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/scta_back.sv
`timescale 1ns / 1ps

module scta_back #(
  parameter int RING_DEPTH = scta_pkg::RING_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  scta_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  output logic [7:0]     out_character,
  output logic           out_was_empty,
  output logic           out_snapshot_requested,
  output logic           out_snapshot_taken
);

  localparam int AW = $clog2(RING_DEPTH);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_CHECK = 1'b1;

  logic          state_r, state_nxt;
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [AW-1:0] rptr_inc, wptr_inc;
  logic          ctrl_r, ctrl_nxt;
  logic          sticky_r, sticky_nxt;
  logic          valid_r, valid_nxt;
  logic [7:0]    char_r, char_nxt;
  logic          empty_r, empty_nxt;
  logic          req_r, req_nxt;
  logic          taken_r, taken_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  scta_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr_r),
    .wdata (q_head.value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rptr_inc = (rptr_r == AW'(RING_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
  assign wptr_inc = (wptr_r == AW'(RING_DEPTH - 1)) ? '0 : wptr_r + 1'b1;

  always_comb begin
    state_nxt  = state_r;
    wptr_nxt   = wptr_r;
    rptr_nxt   = rptr_r;
    ctrl_nxt   = ctrl_r;
    sticky_nxt = sticky_r;
    valid_nxt  = 1'b0;
    char_nxt   = char_r;
    empty_nxt  = empty_r;
    req_nxt    = req_r;
    taken_nxt  = taken_r;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = rptr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          priority if (!q_head.is_read) begin
            // Store and advance; no full check, old entries get overwritten.
            ram_we   = 1'b1;
            wptr_nxt = wptr_inc;
          end else if (rptr_r == wptr_r) begin
            valid_nxt = 1'b1;
            char_nxt  = 8'h00;
            empty_nxt = 1'b1;
            req_nxt   = 1'b0;
            taken_nxt = sticky_r;
          end else begin
            ram_re    = 1'b1;
            ctrl_nxt  = q_head.ctrl;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        rptr_nxt = rptr_inc;
        if (scta_pkg::is_skipped(ram_rdata)) begin
          // Drop this entry; fetch the next one or report empty.
          if (rptr_inc == wptr_r) begin
            valid_nxt = 1'b1;
            char_nxt  = 8'h00;
            empty_nxt = 1'b1;
            req_nxt   = 1'b0;
            taken_nxt = sticky_r;
            state_nxt = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = rptr_inc;
          end
        end else begin
          valid_nxt = 1'b1;
          empty_nxt = 1'b0;
          state_nxt = ST_IDLE;
          if (ctrl_r && ((ram_rdata == scta_pkg::CH_LOWER_S) ||
                         (ram_rdata == scta_pkg::CH_UPPER_S))) begin
            char_nxt   = scta_pkg::CH_NEWLINE;
            req_nxt    = 1'b1;
            sticky_nxt = 1'b1;
            taken_nxt  = 1'b1;
          end else begin
            char_nxt  = ram_rdata;
            req_nxt   = 1'b0;
            taken_nxt = sticky_r;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wptr_r   <= '0;
      rptr_r   <= '0;
      sticky_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wptr_r   <= wptr_nxt;
      rptr_r   <= rptr_nxt;
      sticky_r <= sticky_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctrl_r  <= ctrl_nxt;
    char_r  <= char_nxt;
    empty_r <= empty_nxt;
    req_r   <= req_nxt;
    taken_r <= taken_nxt;
  end

  assign out_valid              = valid_r;
  assign out_character          = char_r;
  assign out_was_empty          = empty_r;
  assign out_snapshot_requested = req_r;
  assign out_snapshot_taken     = taken_r;

endmodule

>>> rtl/scancode_to_ascii_ring_buffer.sv
`timescale 1ns / 1ps

// Keyboard scancode front end with a character ring.
// Input: raise start with in_operation and in_scan_code; the transfer happens
// at a clock edge where start is high and busy is low. in_operation 0 hands
// in a set-1 scancode (no result); 1 asks for the next character (one result).
// Output: out_valid is high for exactly one cycle with out_character,
// out_was_empty, out_snapshot_requested and out_snapshot_taken. The receiver
// cannot stall, so results never wait.
// Flow: a transfer enters a two-entry command queue; the back end drains one
// command at a time. A scancode costs one ring write. A read walks the ring
// through its one read port, one entry a cycle, dropping skipped entries until
// one can be delivered or the ring runs empty; a read of an empty ring answers
// without a ring read.
// busy is high while the queue is full, so the front end keeps taking items
// while the back end works.
// Reset clears the modifier flags, both ring pointers, the snapshot flag and
// the queue; ring contents are not cleared and need no clearing pass.
module scancode_to_ascii_ring_buffer #(
  parameter int RING_DEPTH = scta_pkg::RING_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_operation,
  input  logic [7:0] in_scan_code,
  output logic       out_valid,
  output logic [7:0] out_character,
  output logic       out_was_empty,
  output logic       out_snapshot_requested,
  output logic       out_snapshot_taken
);

  logic           accept;
  logic           push;
  scta_pkg::cmd_t push_cmd;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  scta_pkg::cmd_t q_head;

  // Take an item whenever the queue has room.
  assign busy   = q_full;
  assign accept = start & ~q_full;

  // Front: track modifiers, translate codes, queue commands.
  scta_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_operation (in_operation),
    .in_scan_code (in_scan_code),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  // Queue: decouple the front from the ring sequencer.
  scta_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Back: write the ring, walk it on reads, drop the special entries skipped on read.
  scta_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_valid                (q_valid),
    .q_head                 (q_head),
    .q_pop                  (q_pop),
    .out_valid              (out_valid),
    .out_character          (out_character),
    .out_was_empty          (out_was_empty),
    .out_snapshot_requested (out_snapshot_requested),
    .out_snapshot_taken     (out_snapshot_taken)
  );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

// Scancode front end with character ring: a shadow copy of the flags and the
// ring predicts every read, and a negedge monitor compares each result strobe
// against the oldest pending prediction.
module testbench;

  // Set-1 code of the 's' key; with control held its read becomes a newline.
  localparam logic [7:0] KEY_S = 8'h1F;
  localparam int TABLE_LAST = 57;
  localparam int REPORT_LIMIT = 10;

  // Two-column key table, plain and shifted, indexed by scancode.
  localparam logic [7:0] PLAIN_COL [58] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h20
  };
  localparam logic [7:0] SHIFT_COL [58] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h20
  };

  localparam logic [7:0] MODIFIER_CODES [7] = '{
    scta_pkg::SC_LSHIFT_PRESS, scta_pkg::SC_RSHIFT_PRESS,
    scta_pkg::SC_LSHIFT_RELEASE, scta_pkg::SC_RSHIFT_RELEASE,
    scta_pkg::SC_CAPS_PRESS, scta_pkg::SC_CTRL_PRESS, scta_pkg::SC_CTRL_RELEASE
  };
  localparam logic [7:0] RAW_KEY_CODES [6] = '{
    scta_pkg::SC_ESC, scta_pkg::SC_F1, scta_pkg::SC_UP, scta_pkg::SC_LEFT,
    scta_pkg::SC_RIGHT, scta_pkg::SC_DOWN
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       was_empty;
    logic       snap_req;
    logic       snap_taken;
  } char_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_operation = scta_pkg::OP_SCAN;
  logic [7:0] in_scan_code = 8'h00;
  logic       out_valid;
  logic [7:0] out_character;
  logic       out_was_empty;
  logic       out_snapshot_requested;
  logic       out_snapshot_taken;

  // Shadow state of the keyboard front end.
  logic       shift_down;
  logic       caps_lock;
  logic       ctrl_down;
  logic [7:0] ring_copy [256];
  logic [7:0] wr_idx;
  logic [7:0] rd_idx;
  logic       snap_flag;

  char_result_t pending_chars[$];

  int idle_pct = 0;
  int fail_count = 0;
  int n_scan = 0;
  int n_read = 0;
  int n_checked = 0;
  int n_snap = 0;
  int n_empty = 0;

  scancode_to_ascii_ring_buffer DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_operation           (in_operation),
    .in_scan_code           (in_scan_code),
    .out_valid              (out_valid),
    .out_character          (out_character),
    .out_was_empty          (out_was_empty),
    .out_snapshot_requested (out_snapshot_requested),
    .out_snapshot_taken     (out_snapshot_taken)
  );

  always #1 clk = ~clk;

  // Bound the whole run; a healthy run ends far earlier.
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic logic stored_raw(input logic [7:0] c);
    return (c == scta_pkg::SC_ESC) || (c == scta_pkg::SC_LSHIFT_PRESS) ||
           (c == scta_pkg::SC_RSHIFT_PRESS) || (c == scta_pkg::SC_CAPS_PRESS) ||
           (c == scta_pkg::SC_F1) || (c == scta_pkg::SC_UP) ||
           (c == scta_pkg::SC_LEFT) || (c == scta_pkg::SC_RIGHT) ||
           (c == scta_pkg::SC_DOWN);
  endfunction

  // Update the modifiers, then store a translated or raw entry for press
  // codes up to the top of the press range.
  function automatic void apply_scancode(input logic [7:0] c);
    logic       col;
    logic [7:0] plain;
    logic [7:0] entry;
    if (c == scta_pkg::SC_LSHIFT_PRESS || c == scta_pkg::SC_RSHIFT_PRESS)
      shift_down = 1'b1;
    if (c == scta_pkg::SC_LSHIFT_RELEASE || c == scta_pkg::SC_RSHIFT_RELEASE)
      shift_down = 1'b0;
    if (c == scta_pkg::SC_CAPS_PRESS) caps_lock = ~caps_lock;
    if (c == scta_pkg::SC_CTRL_PRESS) ctrl_down = 1'b1;
    if (c == scta_pkg::SC_CTRL_RELEASE) ctrl_down = 1'b0;
    if (c > scta_pkg::SC_MAX_PRESS) return;
    if (stored_raw(c)) begin
      entry = c;
    end else if (c < scta_pkg::SC_TABLE_KEYS) begin
      plain = PLAIN_COL[c];
      col = shift_down;
      // Caps lock flips the column for letters only.
      if (caps_lock && plain >= scta_pkg::CH_LOWER_A &&
          plain <= scta_pkg::CH_LOWER_Z) col = ~col;
      entry = col ? SHIFT_COL[c] : PLAIN_COL[c];
    end else begin
      entry = 8'h00;
    end
    ring_copy[wr_idx] = entry;
    wr_idx = wr_idx + 8'd1;
  endfunction

  // Consume entries until one is deliverable; raw codes other than '6', ';'
  // and ':' are dropped on the way.
  function automatic void predict_read();
    char_result_t r;
    logic [7:0]   v;
    r = '{ch: 8'h00, was_empty: 1'b1, snap_req: 1'b0, snap_taken: 1'b0};
    while (rd_idx != wr_idx) begin
      v = ring_copy[rd_idx];
      ring_copy[rd_idx] = 8'h00;
      rd_idx = rd_idx + 8'd1;
      if (stored_raw(v) && v != scta_pkg::SC_RSHIFT_PRESS &&
          v != scta_pkg::SC_CAPS_PRESS && v != scta_pkg::SC_F1)
        continue;
      r.was_empty = 1'b0;
      r.ch = v;
      if (ctrl_down && (v == scta_pkg::CH_LOWER_S || v == scta_pkg::CH_UPPER_S)) begin
        snap_flag = 1'b1;
        r.snap_req = 1'b1;
        r.ch = scta_pkg::CH_NEWLINE;
        n_snap++;
      end
      break;
    end
    r.snap_taken = snap_flag;
    if (r.was_empty) n_empty++;
    pending_chars.push_back(r);
  endfunction

  // Offer one item, sometimes after a random gap, and hold it until busy is low at
  // a rising edge. Sample busy at the falling edge so the decision is race free.
  task automatic send_item(input logic op, input logic [7:0] code);
    bit taken;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      in_operation <= 1'($urandom_range(0, 1));
      in_scan_code <= 8'($urandom_range(0, 255));
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_scan_code <= code;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    if (op == scta_pkg::OP_READ) begin
      n_read++;
      predict_read();
    end else begin
      n_scan++;
      apply_scancode(code);
    end
  endtask

  task automatic scan(input logic [7:0] code);
    send_item(scta_pkg::OP_SCAN, code);
  endtask

  task automatic read_char();
    send_item(scta_pkg::OP_READ, 8'($urandom_range(0, 255)));
  endtask

  // Drop start, then wait for every pending read to come back.
  task automatic wait_drain();
    int guard;
    start <= 1'b0;
    guard = 0;
    while (pending_chars.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  // Extremes of the code range, every flag code but the left shift release, raw
  // codes both kept and dropped on read, codes past the table, codes above the
  // press range, an empty read and control plus s.
  task automatic test_directed();
    read_char();
    scan(8'h00);
    scan(scta_pkg::SC_CAPS_PRESS);
    scan(8'h1E);
    scan(scta_pkg::SC_LSHIFT_PRESS);
    scan(8'h1E);
    scan(scta_pkg::SC_RSHIFT_PRESS);
    scan(scta_pkg::SC_RSHIFT_RELEASE);
    scan(scta_pkg::SC_F1);
    scan(scta_pkg::SC_ESC);
    scan(scta_pkg::SC_RIGHT);
    scan(scta_pkg::SC_MAX_PRESS);
    scan(8'hFF);
    scan(scta_pkg::SC_CTRL_PRESS);
    scan(KEY_S);
    scan(scta_pkg::SC_CTRL_RELEASE);
    repeat (10) read_char();
  endtask

  // Plain typing: mostly key presses with modifiers and reads, some noise.
  task automatic test_typing(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) read_char();
      else if (pick < 65) scan(8'($urandom_range(0, TABLE_LAST)));
      else if (pick < 72) scan(KEY_S);
      else if (pick < 85) scan(MODIFIER_CODES[$urandom_range(0, 6)]);
      else if (pick < 92) scan(RAW_KEY_CODES[$urandom_range(0, 5)]);
      else scan(8'($urandom_range(0, 255)));
    end
  endtask

  // Empty the ring, then write exactly one lap so the write pointer catches
  // the read pointer and the ring reads as empty; then refill a little.
  task automatic test_ring_wrap();
    while (rd_idx != wr_idx) read_char();
    repeat (256) scan(8'($urandom_range(0, scta_pkg::SC_MAX_PRESS)));
    read_char();
    repeat ($urandom_range(10, 20)) scan(8'($urandom_range(0, scta_pkg::SC_MAX_PRESS)));
    while (rd_idx != wr_idx) read_char();
    read_char();
  endtask

  // Match every strobe against the oldest prediction, field by field.
  always @(negedge clk) begin : result_check
    char_result_t got;
    char_result_t want;
    if (rst_n && out_valid) begin
      got = '{ch: out_character, was_empty: out_was_empty,
              snap_req: out_snapshot_requested, snap_taken: out_snapshot_taken};
      if (pending_chars.size() == 0) begin
        note_failure($sformatf("result with no read pending: char %h empty %b req %b taken %b",
                               got.ch, got.was_empty, got.snap_req, got.snap_taken));
      end else begin
        want = pending_chars.pop_front();
        n_checked++;
        if (got.ch !== want.ch || got.was_empty !== want.was_empty ||
            got.snap_req !== want.snap_req || got.snap_taken !== want.snap_taken)
          note_failure($sformatf({"mismatch: expected char %h empty %b req %b taken %b,",
                                  " got char %h empty %b req %b taken %b"},
            want.ch, want.was_empty, want.snap_req, want.snap_taken,
            got.ch, got.was_empty, got.snap_req, got.snap_taken));
      end
    end
  end

  initial begin
    shift_down = 1'b0;
    caps_lock = 1'b0;
    ctrl_down = 1'b0;
    wr_idx = 8'd0;
    rd_idx = 8'd0;
    snap_flag = 1'b0;
    foreach (ring_copy[i]) ring_copy[i] = 8'h00;

    // Hold reset, then release it on a rising edge.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    idle_pct = 21;
    test_typing(420);
    idle_pct = 54;
    test_ring_wrap();
    test_typing(80);
    idle_pct = 0;
    test_typing(420);

    wait_drain();
    if (pending_chars.size() != 0)
      note_failure($sformatf("%0d reads never answered", pending_chars.size()));

    $display("Sent %0d scancodes and %0d reads; checked %0d results.",
             n_scan, n_read, n_checked);
    $display("Covered %0d empty reads, %0d snapshot requests and a full ring lap.",
             n_empty, n_snap);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
